### hdl/hann_windowed_stft_frame_macros.svh
// assertion macros for the hann windowed stft frame block
// used by hann_windowed_stft_frame.sv, needs clk_i and rst_ni in scope
`ifndef HANN_WINDOWED_STFT_FRAME_MACROS_SVH
`define HANN_WINDOWED_STFT_FRAME_MACROS_SVH

// clocked implication, held off during reset
`define HWSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// plain condition that must hold every cycle
`define HWSF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

### hdl/hwsf_pkg.sv
// constants, rom types and elaboration-time rom generators for the stft frame block
// no dependencies; used by hann_windowed_stft_frame.sv
package hwsf_pkg;

  localparam int FRAME_LEN   = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(FRAME_LEN);
  localparam int NUM_BINS    = FRAME_LEN / 2 + 1;
  localparam int CNT_W       = ADDR_W + 1;
  localparam int HOP_W       = 9;
  localparam int HOPC_W      = 8;
  localparam int HOP_MAX     = 256;
  localparam int HOP_RESET   = 16;
  localparam int OUT_W       = 23;
  localparam int COEF_W      = 17;
  localparam int XW_W        = 17;
  localparam int PROD_W      = 2 * COEF_W;
  localparam int ACC_W       = PROD_W + ADDR_W;
  localparam int WIN_DEN     = FRAME_LEN - 1;

  localparam longint unsigned Q31_ONE     = 64'd2147483648;
  localparam longint unsigned HALF_PI_Q31 = 64'd3373259426;

  typedef logic signed [COEF_W-1:0] coef_rom_t [FRAME_LEN];

  function automatic longint cos_poly(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 31;
    term = Q31_ONE;
    sum  = longint'(term);
    term = ((term * x2) >> 31) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 31) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 31) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 31) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 31) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 31) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 31) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 31) / 240; sum = sum + longint'(term);
    term = ((term * x2) >> 31) / 306; sum = sum - longint'(term);
    term = ((term * x2) >> 31) / 380; sum = sum + longint'(term);
    return sum;
  endfunction

  function automatic longint part_w(longint unsigned r);
    longint unsigned x;
    if (r == 0) return longint'(Q31_ONE);
    if (r >= WIN_DEN) return 0;
    x = (HALF_PI_Q31 * r + WIN_DEN / 2) / WIN_DEN;
    return cos_poly(x);
  endfunction

  function automatic longint part_f(longint unsigned r);
    longint unsigned x;
    if (r == 0) return longint'(Q31_ONE);
    if (r >= FRAME_LEN) return 0;
    x = (HALF_PI_Q31 * r + FRAME_LEN / 2) / FRAME_LEN;
    return cos_poly(x);
  endfunction

  function automatic longint cos_w(longint unsigned q);
    longint unsigned quad;
    longint unsigned r;
    longint          res;
    quad = (q / WIN_DEN) & 3;
    r    = q % WIN_DEN;
    case (quad)
      0:       res = part_w(r);
      1:       res = -part_w(WIN_DEN - r);
      2:       res = -part_w(r);
      default: res = part_w(WIN_DEN - r);
    endcase
    return res;
  endfunction

  function automatic longint cos_f(longint unsigned q);
    longint unsigned quad;
    longint unsigned r;
    longint          res;
    quad = (q / FRAME_LEN) & 3;
    r    = q % FRAME_LEN;
    case (quad)
      0:       res = part_f(r);
      1:       res = -part_f(FRAME_LEN - r);
      2:       res = -part_f(r);
      default: res = part_f(FRAME_LEN - r);
    endcase
    return res;
  endfunction

  function automatic longint round16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic coef_rom_t gen_win();
    coef_rom_t rom;
    longint    w;
    for (int i = 0; i < FRAME_LEN; i++) begin
      w = round16(longint'(Q31_ONE) - cos_w(longint'(4 * i)));
      if (w > 65535) w = 65535;
      if (w < 0) w = 0;
      rom[i] = COEF_W'(w);
    end
    return rom;
  endfunction

  function automatic coef_rom_t gen_cos();
    coef_rom_t rom;
    for (int i = 0; i < FRAME_LEN; i++) begin
      rom[i] = COEF_W'(round16(cos_f(longint'(4 * i))));
    end
    return rom;
  endfunction

  function automatic coef_rom_t gen_sin();
    coef_rom_t rom;
    for (int i = 0; i < FRAME_LEN; i++) begin
      rom[i] = COEF_W'(round16(cos_f(longint'(4 * i + 3 * FRAME_LEN))));
    end
    return rom;
  endfunction

  localparam coef_rom_t WIN_ROM = gen_win();
  localparam coef_rom_t COS_ROM = gen_cos();
  localparam coef_rom_t SIN_ROM = gen_sin();

endpackage

### hdl/hann_windowed_stft_frame.sv
// hann windowed stft frame: sample ring, windowing and direct dft on one shared complex mac
// depends on hwsf_pkg, hwsf_ram and hann_windowed_stft_frame_macros.svh
// a sample that completes no frame leaves the block idle, ready for the next sample; a firing sample
// holds input off for the window pass and drain, then the mac beats, drain and push for each bin,
// all on the one complex mac; a stalled output holds the push and so holds input off longer
// reset clears counters, pointer, sequencer and output valid, the hop returns to 16
`include "hann_windowed_stft_frame_macros.svh"

module hann_windowed_stft_frame (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hwsf_pkg::HOP_W-1:0]          cfg_hop_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [hwsf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                start_of_clip_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hwsf_pkg::ADDR_W-1:0]         bin_index_o,
  output logic signed [hwsf_pkg::OUT_W-1:0]   bin_real_o,
  output logic signed [hwsf_pkg::OUT_W-1:0]   bin_imag_o,
  output logic                                frame_last_o
);

  localparam int AW = hwsf_pkg::ADDR_W;
  localparam int CW = hwsf_pkg::COEF_W;
  localparam int PW = hwsf_pkg::PROD_W;
  localparam int ACW = hwsf_pkg::ACC_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WIN    = 3'd1;
  localparam logic [2:0] S_WDRAIN = 3'd2;
  localparam logic [2:0] S_DFT    = 3'd3;
  localparam logic [2:0] S_DDRAIN = 3'd4;
  localparam logic [2:0] S_PUSH   = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [hwsf_pkg::HOP_W-1:0]     hop_len_q, hop_len_d;
  logic [AW-1:0]                  wp_q, wp_d;
  logic [hwsf_pkg::CNT_W-1:0]     fill_q, fill_d;
  logic [hwsf_pkg::HOPC_W-1:0]    hop_q, hop_d;
  logic [AW-1:0]                  n_q, n_d, m_q, m_d, k_q, k_d;
  logic                           v1_q, v1_d, v2_q;
  logic [AW-1:0]                  n1_q, n2_q, m1_q;
  logic                           first1_q, first2_q;
  logic signed [PW-1:0]           p_re_q, p_im_q, p_re_d, p_im_d;
  logic signed [ACW-1:0]          acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic                           out_valid_q, out_valid_d;
  logic [AW-1:0]                  bin_index_q;
  logic signed [hwsf_pkg::OUT_W-1:0] bin_real_q, bin_imag_q;
  logic                           frame_last_q;

  logic                           accept, fire, win_phase, load, last_n, pipe_empty;
  logic [AW-1:0]                  wp_base;
  logic [hwsf_pkg::CNT_W-1:0]     fill_base;
  logic [hwsf_pkg::HOPC_W-1:0]    hop_base, hop_reload;
  logic [AW-1:0]                  ring_raddr;
  logic [hwsf_pkg::SAMPLE_BITS-1:0] ring_rdata;
  logic [hwsf_pkg::XW_W-1:0]      work_rdata, work_wdata;
  logic signed [CW-1:0]           op_a, op_re, op_im;
  logic signed [PW-1:0]           p_round;
  logic signed [ACW-1:0]          re_round, im_round, re_base, im_base;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign win_phase   = (state_q == S_WIN) || (state_q == S_WDRAIN);
  assign last_n      = (n_q == AW'(hwsf_pkg::FRAME_LEN - 1));
  assign pipe_empty  = !v1_q && !v2_q;
  assign load        = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  // clip start restarts ring and counters before this sample lands
  assign wp_base   = start_of_clip_i ? '0 : wp_q;
  assign fill_base = start_of_clip_i ? '0 : fill_q;
  assign hop_base  = start_of_clip_i ? '0 : hop_q;

  always_comb begin
    if (hop_len_q == '0) begin
      hop_reload = '0;
    end else if (hop_len_q > hwsf_pkg::HOP_W'(hwsf_pkg::HOP_MAX)) begin
      hop_reload = hwsf_pkg::HOPC_W'(hwsf_pkg::HOP_MAX - 1);
    end else begin
      hop_reload = hwsf_pkg::HOPC_W'(hop_len_q - 1'b1);
    end
  end

  always_comb begin
    fire   = 1'b0;
    fill_d = fill_q;
    hop_d  = hop_q;
    wp_d   = wp_q;
    if (accept) begin
      wp_d   = wp_base + 1'b1;
      fill_d = fill_base;
      hop_d  = hop_base;
      if (fill_base < hwsf_pkg::CNT_W'(hwsf_pkg::FRAME_LEN)) begin
        fill_d = fill_base + 1'b1;
        fire   = (fill_base == hwsf_pkg::CNT_W'(hwsf_pkg::FRAME_LEN - 1));
      end else if (hop_base == '0) begin
        fire = 1'b1;
      end else begin
        hop_d = hop_base - 1'b1;
      end
      if (fire) begin
        hop_d = hop_reload;
      end
    end
  end

  assign hop_len_d = (cfg_valid_i && cfg_ready_o) ? cfg_hop_i : hop_len_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    m_d     = m_q;
    k_d     = k_q;
    v1_d    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && fire) begin
          state_d = S_WIN;
          n_d     = '0;
        end
      end
      S_WIN: begin
        v1_d = 1'b1;
        n_d  = n_q + 1'b1;
        if (last_n) state_d = S_WDRAIN;
      end
      S_WDRAIN: begin
        if (pipe_empty) begin
          state_d = S_DFT;
          n_d     = '0;
          m_d     = '0;
          k_d     = '0;
        end
      end
      S_DFT: begin
        v1_d = 1'b1;
        n_d  = n_q + 1'b1;
        m_d  = m_q + k_q;
        if (last_n) state_d = S_DDRAIN;
      end
      S_DDRAIN: begin
        if (pipe_empty) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (load) begin
          if (k_q == AW'(hwsf_pkg::NUM_BINS - 1)) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_DFT;
            k_d     = k_q + 1'b1;
            n_d     = '0;
            m_d     = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ring_raddr = wp_q + n_q;

  hwsf_ram #(
    .WIDTH (hwsf_pkg::SAMPLE_BITS),
    .DEPTH (hwsf_pkg::FRAME_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_base),
    .wdata_i (sample_i),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  hwsf_ram #(
    .WIDTH (hwsf_pkg::XW_W),
    .DEPTH (hwsf_pkg::FRAME_LEN)
  ) u_work (
    .clk_i   (clk_i),
    .we_i    (v2_q && win_phase),
    .waddr_i (n2_q),
    .wdata_i (work_wdata),
    .raddr_i (n_q),
    .rdata_o (work_rdata)
  );

  // shared complex mac: stage 1 multiplies, stage 2 rounds to work ram or accumulates
  always_comb begin
    if (win_phase) begin
      op_a  = CW'($signed(ring_rdata));
      op_re = hwsf_pkg::WIN_ROM[n1_q];
    end else begin
      op_a  = $signed(work_rdata);
      op_re = hwsf_pkg::COS_ROM[m1_q];
    end
    op_im  = hwsf_pkg::SIN_ROM[m1_q];
    p_re_d = op_a * op_re;
    p_im_d = op_a * op_im;
  end

  assign p_round    = (p_re_q + PW'(32768)) >>> 16;
  assign work_wdata = p_round[hwsf_pkg::XW_W-1:0];

  assign re_base  = first2_q ? '0 : acc_re_q;
  assign im_base  = first2_q ? '0 : acc_im_q;
  assign acc_re_d = (v2_q && !win_phase) ? re_base + ACW'(p_re_q) : acc_re_q;
  assign acc_im_d = (v2_q && !win_phase) ? im_base - ACW'(p_im_q) : acc_im_q;

  assign re_round = (acc_re_q + ACW'(16384)) >>> 15;
  assign im_round = (acc_im_q + ACW'(16384)) >>> 15;

  assign out_valid_d = load | (out_valid_q & !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hop_len_q   <= hwsf_pkg::HOP_W'(hwsf_pkg::HOP_RESET);
      wp_q        <= '0;
      fill_q      <= '0;
      hop_q       <= '0;
      n_q         <= '0;
      m_q         <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hop_len_q   <= hop_len_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      hop_q       <= hop_d;
      n_q         <= n_d;
      m_q         <= m_d;
      k_q         <= k_d;
      v1_q        <= v1_d;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q     <= n_q;
    m1_q     <= m_q;
    first1_q <= (n_q == '0);
    n2_q     <= n1_q;
    first2_q <= first1_q;
    p_re_q   <= p_re_d;
    p_im_q   <= p_im_d;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    if (load) begin
      bin_index_q  <= k_q;
      bin_real_q   <= re_round[hwsf_pkg::OUT_W-1:0];
      bin_imag_q   <= im_round[hwsf_pkg::OUT_W-1:0];
      frame_last_q <= (k_q == AW'(hwsf_pkg::NUM_BINS - 1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_index_o  = bin_index_q;
  assign bin_real_o   = bin_real_q;
  assign bin_imag_o   = bin_imag_q;
  assign frame_last_o = frame_last_q;

  `HWSF_ASSERT(a_fire_starts_window, (accept && fire) |=> (state_q == S_WIN),
               "completed frame did not start the window pass")
  `HWSF_ASSERT(a_push_sets_valid, load |=> out_valid_o, "bin push did not raise out valid")
  `HWSF_ASSERT_ALWAYS(a_pipe_idle, !(v2_q && (state_q == S_IDLE || state_q == S_PUSH)),
                      "mac pipeline busy outside a pass")

endmodule

### hdl/hwsf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hwsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
